/* sv/ipfwd_pkg.sv */
// ipfwd_pkg: shared types, constants and the header checksum sum for the
// ipv4 forwarding header rewrite block. No dependencies.
`default_nettype none

package ipfwd_pkg;

   // field and bus widths fixed by the item layout
   localparam int ENTRY_IDX_W = 3;
   localparam int MAX_SLOTS   = 2 ** ENTRY_IDX_W;
   localparam int COUNT_W     = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int REQ_TDATA_W = 312;
   localparam int RSP_TDATA_W = 128;
   localparam int SUM_W       = 20;
   localparam int FOLD_W      = 17;

   // result action codes
   typedef enum logic [2:0] {
      ACT_FORWARD       = 3'd0,
      ACT_ROUTE_WRITTEN = 3'd1,
      ACT_WRONG_MAC     = 3'd2,
      ACT_FOR_ROUTER    = 3'd3,
      ACT_TTL_EXPIRED   = 3'd4,
      ACT_NO_ROUTE      = 3'd5
   } action_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROUTE_COUNT = 3'd0,
      CSR_PORT0_MAC   = 3'd1,
      CSR_PORT1_MAC   = 3'd2,
      CSR_PORT0_IP    = 3'd3,
      CSR_PORT1_IP    = 3'd4
   } csr_index_type;

   // one routing table entry
   typedef struct packed {
      logic [31:0] net;
      logic [31:0] mask;
      logic [47:0] mac;
      logic        port;
   } route_type;

   // chosen route after the longest-mask pick
   typedef struct packed {
      logic        found;
      logic        port;
      logic [47:0] mac;
   } pick_type;

   // result payload, lowest field in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [15:0] new_checksum;
      logic [7:0]  new_ttl;
      logic [47:0] new_dst_mac;
      logic [47:0] new_src_mac;
      logic        out_port;
   } rsp_data_type;

   // unfolded one's complement sum of the fixed 20 header bytes
   function automatic logic [SUM_W-1:0] csum_sum(
      input logic [31:0] w0,
      input logic [31:0] w1,
      input logic [15:0] tp,
      input logic [31:0] sip,
      input logic [31:0] dip
   );
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
      logic [SUM_W-1:0] c;
      a = SUM_W'(w0[31:16]) + SUM_W'(w0[15:0]) + SUM_W'(w1[31:16]);
      b = SUM_W'(w1[15:0]) + SUM_W'(tp) + SUM_W'(sip[31:16]);
      c = SUM_W'(sip[15:0]) + SUM_W'(dip[31:16]) + SUM_W'(dip[15:0]);
      return a + b + c;
   endfunction

endpackage

`default_nettype wire

/* sv/ipfwd_table.sv */
// ipfwd_table: routing table registers and the per-entry destination match.
// Depends on ipfwd_pkg.
`default_nettype none

module ipfwd_table
   import ipfwd_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ENTRY_IDX_W-1:0] wr_index,
   input  wire route_type          wr_entry,
   input  wire logic [COUNT_W-1:0] route_count,
   input  wire logic [31:0]        dst_ip,
   output route_type               entries [SLOTS],
   output logic [SLOTS-1:0]        hit
);

   route_type table_ff [SLOTS];

   // entry write, slots past the table are dropped
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (wr_en && wr_index == ENTRY_IDX_W'(i)) begin
            table_ff[i] <= wr_entry;
         end
      end
   end

   // parallel network match over the searched entries
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         entries[i] = table_ff[i];
         hit[i]     = (COUNT_W'(i) < route_count) &&
                      ((dst_ip & table_ff[i].mask) == table_ff[i].net);
      end
   end

endmodule

`default_nettype wire

/* sv/ipfwd_pick.sv */
// ipfwd_pick: longest-mask winner among matching entries, later entry wins a
// tie, and the winner's next hop. Depends on ipfwd_pkg.
`default_nettype none

module ipfwd_pick
   import ipfwd_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  wire logic [SLOTS-1:0] hit,
   input  wire route_type        entries [SLOTS],
   output logic [SLOTS-1:0]      win,
   output pick_type              pick
);

   // pairwise mask ranking, every pair compared in parallel
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         win[i] = hit[i];
         for (int j = 0; j < SLOTS; j++) begin
            if (j > i && hit[j] && !(entries[j].mask < entries[i].mask)) begin
               win[i] = 1'b0;
            end
            if (j < i && hit[j] && entries[j].mask > entries[i].mask) begin
               win[i] = 1'b0;
            end
         end
      end
   end

   // and-or select of the winning entry
   always_comb begin
      pick.found = |hit;
      pick.port  = 1'b0;
      pick.mac   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         pick.port = pick.port | (win[i] & entries[i].port);
         pick.mac  = pick.mac | ({48{win[i]}} & entries[i].mac);
      end
   end

endmodule

`default_nettype wire

/* sv/ipv4_forward_header_rewrite.sv */
// ipv4_forward_header_rewrite: top level, four-stage forwarding pipeline.
// Depends on ipfwd_pkg, ipfwd_table and ipfwd_pick.
//
//   channel | dir | handshake             | payload
//   req_    | in  | req_tvalid/req_tready | req_tdata fields, req_tuser = req_type
//   rsp_    | out | rsp_tvalid/rsp_tready | rsp_tdata fields, rsp_tuser = action
//   csr_    | in  | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
// One item per cycle unless the output stalls.
// Stages: input register, match and checksum sum, longest-mask pick and
// first fold, output register with rewrite and final fold.
// Route writes update the table at their input transfer, seen by later headers.
// Each stage holds while the next one is full and stalled; reset empties
// the pipeline and clears the configuration registers.
`default_nettype none

module ipv4_forward_header_rewrite
   import ipfwd_pkg::*;
#(
   parameter int ROUTE_ENTRIES = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // slave side
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // entry_index, entry_net_mask, entry_next_hop_mac, entry_port, in_port,
   // frame_dst_mac, hdr_word0, hdr_word1, ttl_protocol, src_ip, dst_ip, zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  wire logic                   req_tuser,
   // master side
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // out_port, new_src_mac, new_dst_mac, new_ttl, new_checksum, zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // action
   output logic [2:0]                  rsp_tuser,
   // configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int Slots = (ROUTE_ENTRIES < MAX_SLOTS) ? ROUTE_ENTRIES : MAX_SLOTS;

   // input field unpacking
   logic [ENTRY_IDX_W-1:0] f_entry_index;
   logic [63:0]            f_entry_net_mask;
   logic [47:0]            f_entry_mac;
   logic                   f_entry_port;
   logic                   f_in_port;
   logic [47:0]            f_dst_mac;
   logic [31:0]            f_w0;
   logic [31:0]            f_w1;
   logic [15:0]            f_tp;
   logic [31:0]            f_sip;
   logic [31:0]            f_dip;

   assign f_entry_index    = req_tdata[2:0];
   assign f_entry_net_mask = req_tdata[66:3];
   assign f_entry_mac      = req_tdata[114:67];
   assign f_entry_port     = req_tdata[115];
   assign f_in_port        = req_tdata[116];
   assign f_dst_mac        = req_tdata[164:117];
   assign f_w0             = req_tdata[196:165];
   assign f_w1             = req_tdata[228:197];
   assign f_tp             = req_tdata[244:229];
   assign f_sip            = req_tdata[276:245];
   assign f_dip            = req_tdata[308:277];

   // configuration registers
   logic [COUNT_W-1:0] route_count_ff;
   logic [47:0]        port0_mac_ff;
   logic [47:0]        port1_mac_ff;
   logic [31:0]        port0_ip_ff;
   logic [31:0]        port1_ip_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         route_count_ff <= '0;
         port0_mac_ff   <= '0;
         port1_mac_ff   <= '0;
         port0_ip_ff    <= '0;
         port1_ip_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROUTE_COUNT: route_count_ff <= csr_data[COUNT_W-1:0];
            CSR_PORT0_MAC:   port0_mac_ff   <= csr_data[47:0];
            CSR_PORT1_MAC:   port1_mac_ff   <= csr_data[47:0];
            CSR_PORT0_IP:    port0_ip_ff    <= csr_data[31:0];
            CSR_PORT1_IP:    port1_ip_ff    <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // stage handshake chain
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic req_xfer;

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // stage 1: input register
   logic        s1_type_ff;
   logic        s1_in_port_ff;
   logic [47:0] s1_dst_mac_ff;
   logic [31:0] s1_w0_ff;
   logic [31:0] s1_w1_ff;
   logic [15:0] s1_tp_ff;
   logic [31:0] s1_sip_ff;
   logic [31:0] s1_dip_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_type_ff    <= req_tuser;
         s1_in_port_ff <= f_in_port;
         s1_dst_mac_ff <= f_dst_mac;
         s1_w0_ff      <= f_w0;
         s1_w1_ff      <= f_w1;
         s1_tp_ff      <= f_tp;
         s1_sip_ff     <= f_sip;
         s1_dip_ff     <= f_dip;
      end
   end

   // route table, written at the route write transfer
   route_type        wr_entry;
   route_type        tbl_entries [Slots];
   logic [Slots-1:0] tbl_hit;

   assign wr_entry.net  = f_entry_net_mask[63:32];
   assign wr_entry.mask = f_entry_net_mask[31:0];
   assign wr_entry.mac  = f_entry_mac;
   assign wr_entry.port = f_entry_port;

   ipfwd_table #(
      .SLOTS (Slots)
   ) u_table (
      .clock       (clock),
      .wr_en       (req_xfer && !req_tuser),
      .wr_index    (f_entry_index),
      .wr_entry    (wr_entry),
      .route_count (route_count_ff),
      .dst_ip      (s1_dip_ff),
      .entries     (tbl_entries),
      .hit         (tbl_hit)
   );

   // stage 2 inputs: acceptance checks and checksum sum with the new ttl
   action_type       act2_in;
   logic [7:0]       ttl2_in;
   logic [SUM_W-1:0] sum2_in;
   logic [47:0]      my_mac;
   logic [31:0]      my_ip;

   assign my_mac  = s1_in_port_ff ? port1_mac_ff : port0_mac_ff;
   assign my_ip   = s1_in_port_ff ? port1_ip_ff : port0_ip_ff;
   assign ttl2_in = s1_tp_ff[15:8] - 8'd1;
   assign sum2_in = csum_sum(s1_w0_ff, s1_w1_ff, {ttl2_in, s1_tp_ff[7:0]},
                             s1_sip_ff, s1_dip_ff);

   always_comb begin
      priority if (!s1_type_ff)             act2_in = ACT_ROUTE_WRITTEN;
      else if (s1_dst_mac_ff != my_mac)     act2_in = ACT_WRONG_MAC;
      else if (s1_dip_ff == my_ip)          act2_in = ACT_FOR_ROUTER;
      else if (s1_tp_ff[15:8] <= 8'd1)      act2_in = ACT_TTL_EXPIRED;
      else                                  act2_in = ACT_FORWARD;
   end

   // stage 2 register, table snapshot taken with the header
   action_type       act2_ff;
   logic [7:0]       ttl2_ff;
   logic [SUM_W-1:0] sum2_ff;
   logic [Slots-1:0] hit2_ff;
   route_type        ent2_ff [Slots];

   always_ff @(posedge clock) begin
      if (rdy2) begin
         act2_ff <= act2_in;
         ttl2_ff <= ttl2_in;
         sum2_ff <= sum2_in;
         hit2_ff <= tbl_hit;
         for (int i = 0; i < Slots; i++) begin
            ent2_ff[i] <= tbl_entries[i];
         end
      end
   end

   // longest-mask pick
   logic [Slots-1:0] win;
   pick_type         pick;

   ipfwd_pick #(
      .SLOTS (Slots)
   ) u_pick (
      .hit     (hit2_ff),
      .entries (ent2_ff),
      .win     (win),
      .pick    (pick)
   );

   // stage 3 inputs: no-route drop and first checksum fold
   action_type        act3_in;
   logic [FOLD_W-1:0] fold3_in;

   assign act3_in  = (act2_ff == ACT_FORWARD && !pick.found) ? ACT_NO_ROUTE : act2_ff;
   assign fold3_in = FOLD_W'(sum2_ff[SUM_W-1:16]) + FOLD_W'(sum2_ff[15:0]);

   action_type        act3_ff;
   logic [7:0]        ttl3_ff;
   logic [FOLD_W-1:0] fold3_ff;
   pick_type          pick3_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         act3_ff  <= act3_in;
         ttl3_ff  <= ttl2_ff;
         fold3_ff <= fold3_in;
         pick3_ff <= pick;
      end
   end

   // stage 4 inputs: header rewrite, final fold, zeros unless forwarded
   rsp_data_type      data4_in;
   logic [FOLD_W-1:0] fold4;

   assign fold4 = FOLD_W'(fold3_ff[FOLD_W-1]) + FOLD_W'(fold3_ff[15:0]);

   always_comb begin
      data4_in = '0;
      if (act3_ff == ACT_FORWARD) begin
         data4_in.out_port     = pick3_ff.port;
         data4_in.new_src_mac  = pick3_ff.port ? port1_mac_ff : port0_mac_ff;
         data4_in.new_dst_mac  = pick3_ff.mac;
         data4_in.new_ttl      = ttl3_ff;
         data4_in.new_checksum = ~fold4[15:0];
      end
   end

   // output register
   action_type   act4_ff;
   rsp_data_type data4_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         act4_ff  <= act3_ff;
         data4_ff <= data4_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tuser  = act4_ff;
   assign rsp_tdata  = data4_ff;

   // checks, the pick only for headers that reach the table search
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      v4_ff && act4_ff != ACT_FORWARD |-> data4_ff == '0)
      else $error("dropped or write result carries a nonzero payload");

   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      v4_ff && act4_ff == ACT_FORWARD |-> data4_ff.new_ttl != 8'd0)
      else $error("forwarded header with zero ttl");

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      v2_ff && act2_ff == ACT_FORWARD |-> $onehot0(win))
      else $error("more than one route picked");

   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      v2_ff && act2_ff == ACT_FORWARD && (|hit2_ff) |-> $onehot(win))
      else $error("matching routes but no winner");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

/* tb/tb_ipv4_forward_header_rewrite.sv */
// Self-checking testbench for ipv4_forward_header_rewrite: route writes and
// packet headers on the request stream, forwarding verdicts checked in order.
// Depends on ipfwd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_ipv4_forward_header_rewrite;
   import ipfwd_pkg::*;

   localparam int SLOTS        = 8;
   localparam int PIPE_LATENCY = 3;
   localparam int LONG_STALL   = 300;
   localparam int RANDOM_ITEMS = 600;

   // one request: a route write or a packet header
   typedef struct {
      bit          is_header;
      logic [2:0]  entry_index;
      logic [63:0] entry_net_mask;
      logic [47:0] hop_mac;
      logic        entry_port;
      logic        in_port;
      logic [47:0] frame_dst_mac;
      logic [31:0] hdr_word0;
      logic [31:0] hdr_word1;
      logic [15:0] ttl_protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
   } fwd_request_type;

   // one forwarding verdict
   typedef struct {
      action_type  action;
      logic        out_port;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [7:0]  ttl;
      logic [15:0] checksum;
   } fwd_verdict_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire logic              req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   wire logic              rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire logic [RSP_TDATA_W-1:0] rsp_tdata;
   wire logic [2:0]        rsp_tuser;
   logic                   csr_valid = 1'b0;
   wire logic              csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow configuration and routing table
   logic [3:0]  cfg_route_count = '0;
   logic [47:0] cfg_port0_mac = '0;
   logic [47:0] cfg_port1_mac = '0;
   logic [31:0] cfg_port0_ip = '0;
   logic [31:0] cfg_port1_ip = '0;
   logic [31:0] tbl_net [SLOTS];
   logic [31:0] tbl_mask [SLOTS];
   logic [47:0] tbl_mac [SLOTS];
   logic        tbl_port [SLOTS];

   fwd_request_type req_backlog [$];
   fwd_verdict_type expected_verdicts [$];
   fwd_request_type req_on_bus;

   int sender_gap_pct = 0;
   int receiver_gap_pct = 0;
   int error_count = 0;
   bit long_stall_go = 1'b0;
   logic rx_hold = 1'b0;

   ipv4_forward_header_rewrite #(
      .ROUTE_ENTRIES(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one's complement sum over the fixed 20 header bytes, checksum field zero
   function automatic logic [15:0] header_checksum(input logic [31:0] w0,
         input logic [31:0] w1, input logic [15:0] tp, input logic [31:0] sip,
         input logic [31:0] dip);
      logic [31:0] s;
      s = 32'(w0[31:16]) + 32'(w0[15:0]) + 32'(w1[31:16]) + 32'(w1[15:0])
        + 32'(tp) + 32'(sip[31:16]) + 32'(sip[15:0]) + 32'(dip[31:16])
        + 32'(dip[15:0]);
      s = (s >> 16) + (s & 32'h0000_FFFF);
      s = s + (s >> 16);
      return ~s[15:0];
   endfunction

   // verdict for one accepted request; route writes update the shadow table
   function automatic fwd_verdict_type forward_decision(input fwd_request_type rq);
      fwd_verdict_type v;
      logic [47:0]  own_mac;
      logic [31:0]  own_ip;
      logic [7:0]   ttl;
      logic [31:0]  best_mask;
      int           span;
      int           best;
      int           i;
      bit           hit;
      v.action   = ACT_FORWARD;
      v.out_port = 1'b0;
      v.src_mac  = '0;
      v.dst_mac  = '0;
      v.ttl      = '0;
      v.checksum = '0;
      if (!rq.is_header) begin
         tbl_net[rq.entry_index]  = rq.entry_net_mask[63:32];
         tbl_mask[rq.entry_index] = rq.entry_net_mask[31:0];
         tbl_mac[rq.entry_index]  = rq.hop_mac;
         tbl_port[rq.entry_index] = rq.entry_port;
         v.action = ACT_ROUTE_WRITTEN;
         return v;
      end
      own_mac = rq.in_port ? cfg_port1_mac : cfg_port0_mac;
      own_ip  = rq.in_port ? cfg_port1_ip : cfg_port0_ip;
      ttl     = rq.ttl_protocol[15:8];
      if (rq.frame_dst_mac != own_mac) begin
         v.action = ACT_WRONG_MAC;
      end else if (rq.dst_ip == own_ip) begin
         v.action = ACT_FOR_ROUTER;
      end else if (ttl <= 8'd1) begin
         v.action = ACT_TTL_EXPIRED;
      end else begin
         // longest mask wins, a later entry wins a tie
         span = (cfg_route_count > SLOTS) ? SLOTS : int'(cfg_route_count);
         hit = 1'b0;
         best = 0;
         best_mask = '0;
         for (i = 0; i < span; i++) begin
            if ((rq.dst_ip & tbl_mask[i]) == tbl_net[i] && tbl_mask[i] >= best_mask) begin
               hit = 1'b1;
               best = i;
               best_mask = tbl_mask[i];
            end
         end
         if (!hit) begin
            v.action = ACT_NO_ROUTE;
         end else begin
            v.out_port = tbl_port[best];
            v.src_mac  = tbl_port[best] ? cfg_port1_mac : cfg_port0_mac;
            v.dst_mac  = tbl_mac[best];
            v.ttl      = ttl - 8'd1;
            v.checksum = header_checksum(rq.hdr_word0, rq.hdr_word1,
                                         {v.ttl, rq.ttl_protocol[7:0]},
                                         rq.src_ip, rq.dst_ip);
         end
      end
      return v;
   endfunction

   // request with every field random but marked as a header, before shaping
   function automatic fwd_request_type noise_request();
      fwd_request_type rq;
      rq.is_header      = 1'b1;
      rq.entry_index    = 3'($urandom());
      rq.entry_net_mask = {$urandom(), $urandom()};
      rq.hop_mac        = 48'({$urandom(), $urandom()});
      rq.entry_port     = 1'($urandom());
      rq.in_port        = 1'($urandom());
      rq.frame_dst_mac  = 48'({$urandom(), $urandom()});
      rq.hdr_word0      = $urandom();
      rq.hdr_word1      = $urandom();
      rq.ttl_protocol   = 16'($urandom());
      rq.src_ip         = $urandom();
      rq.dst_ip         = $urandom();
      return rq;
   endfunction

   // mostly well-formed headers aimed at table entries, some route writes
   function automatic fwd_request_type random_request();
      fwd_request_type rq;
      int unsigned  pick;
      int unsigned  plen;
      int unsigned  slot;
      logic [31:0]  mask;
      rq = noise_request();
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
         rq.is_header = 1'b0;
         plen = $urandom_range(32, 0);
         mask = (plen == 0) ? 32'h0 : (~32'h0 << (32 - plen));
         // contiguous and clean, with host bits, or fully random
         if (pick < 6) begin
            rq.entry_net_mask = {rq.entry_net_mask[63:32] & mask, mask};
         end else if (pick == 6) begin
            rq.entry_net_mask[31:0] = mask;
         end
         return rq;
      end
      if ($urandom_range(99, 0) < 90) begin
         rq.frame_dst_mac = rq.in_port ? cfg_port1_mac : cfg_port0_mac;
      end
      pick = $urandom_range(99, 0);
      if (pick < 85) begin
         slot = $urandom_range(SLOTS - 1, 0);
         rq.dst_ip = (tbl_net[slot] & tbl_mask[slot]) | ($urandom() & ~tbl_mask[slot]);
      end else if (pick < 90) begin
         rq.dst_ip = rq.in_port ? cfg_port1_ip : cfg_port0_ip;
      end
      pick = $urandom_range(99, 0);
      if (pick < 85) begin
         rq.ttl_protocol[15:8] = 8'($urandom_range(255, 2));
      end else if (pick < 92) begin
         rq.ttl_protocol[15:8] = 8'd1;
      end else begin
         rq.ttl_protocol[15:8] = 8'd0;
      end
      return rq;
   endfunction

   function automatic fwd_request_type route_write(input int slot, input logic [31:0] net,
         input logic [31:0] mask, input logic [47:0] mac, input logic port);
      fwd_request_type rq;
      rq = noise_request();
      rq.is_header      = 1'b0;
      rq.entry_index    = 3'(slot);
      rq.entry_net_mask = {net, mask};
      rq.hop_mac        = mac;
      rq.entry_port     = port;
      return rq;
   endfunction

   function automatic fwd_request_type packet_header(input logic inp, input logic [47:0] dmac,
         input logic [31:0] w0, input logic [31:0] w1, input logic [15:0] tp,
         input logic [31:0] sip, input logic [31:0] dip);
      fwd_request_type rq;
      rq = noise_request();
      rq.in_port       = inp;
      rq.frame_dst_mac = dmac;
      rq.hdr_word0     = w0;
      rq.hdr_word1     = w1;
      rq.ttl_protocol  = tp;
      rq.src_ip        = sip;
      rq.dst_ip        = dip;
      return rq;
   endfunction

   // driver: holds an item until its transfer, then offers the next or idles
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_verdicts.push_back(forward_decision(req_on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(99, 0) >= sender_gap_pct) begin
               req_on_bus = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_on_bus.is_header;
               req_tdata  <= {3'b000, req_on_bus.dst_ip, req_on_bus.src_ip,
                              req_on_bus.ttl_protocol, req_on_bus.hdr_word1,
                              req_on_bus.hdr_word0, req_on_bus.frame_dst_mac,
                              req_on_bus.in_port, req_on_bus.entry_port,
                              req_on_bus.hop_mac, req_on_bus.entry_net_mask,
                              req_on_bus.entry_index};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transfer against the oldest verdict
   always @(posedge clock) begin
      rsp_data_type got;
      fwd_verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_data_type'(rsp_tdata);
            if (expected_verdicts.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected result: action %0d data %h", rsp_tuser, rsp_tdata);
               end
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tuser !== want.action || got.out_port !== want.out_port
                   || got.new_src_mac !== want.src_mac || got.new_dst_mac !== want.dst_mac
                   || got.new_ttl !== want.ttl || got.new_checksum !== want.checksum) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  expected action %0d port %0d src %h dst %h ttl %0d csum %h",
                              want.action, want.out_port, want.src_mac, want.dst_mac,
                              want.ttl, want.checksum);
                     $display("  actual   action %0d port %0d src %h dst %h ttl %0d csum %h",
                              rsp_tuser, got.out_port, got.new_src_mac, got.new_dst_mac,
                              got.new_ttl, got.new_checksum);
                  end
               end
            end
         end
         rsp_tready <= !rx_hold && ($urandom_range(99, 0) >= receiver_gap_pct);
      end
   end

   // long receiver hold-off so the pipeline fills and backpressures its input
   initial begin
      wait (long_stall_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (LONG_STALL) @(posedge clock);
      rx_hold <= 1'b0;
   end

   task automatic write_csr(input csr_index_type idx, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      unique case (idx)
         CSR_ROUTE_COUNT: cfg_route_count = value[3:0];
         CSR_PORT0_MAC:   cfg_port0_mac = value;
         CSR_PORT1_MAC:   cfg_port1_mac = value;
         CSR_PORT0_IP:    cfg_port0_ip = value[31:0];
         CSR_PORT1_IP:    cfg_port1_ip = value[31:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_ports(input logic [47:0] m0, input logic [47:0] m1,
         input logic [31:0] ip0, input logic [31:0] ip1);
      write_csr(CSR_PORT0_MAC, m0);
      write_csr(CSR_PORT1_MAC, m1);
      write_csr(CSR_PORT0_IP, 48'(ip0));
      write_csr(CSR_PORT1_IP, 48'(ip1));
   endtask

   // wait until every request is transferred and every verdict has arrived
   task automatic drain_pipeline();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int n;
      for (n = 0; n < count; n++) req_backlog.push_back(random_request());
      drain_pipeline();
   endtask

   initial begin
      logic [47:0] m0;
      logic [47:0] m1;
      m0 = 48'h02_1A_2B_3C_4D_01;
      m1 = 48'h02_1A_2B_3C_4D_02;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full table, then each drop reason and each route kind
      write_csr(CSR_ROUTE_COUNT, 48'd8);
      set_ports(m0, m1, 32'h0A00_0001, 32'hC000_0201);
      req_backlog.push_back(route_write(0, 32'h0A00_0000, 32'hFF00_0000, 48'h0, 1'b0));
      req_backlog.push_back(route_write(1, 32'h0A01_0000, 32'hFFFF_0000,
                                        48'hFFFF_FFFF_FFFF, 1'b1));
      req_backlog.push_back(route_write(2, 32'h0A01_0203, 32'hFFFF_FFFF,
                                        48'h0A_0B_0C_0D_0E_0F, 1'b0));
      // same prefix as slot 1: the later slot takes the tie
      req_backlog.push_back(route_write(3, 32'h0A01_0000, 32'hFFFF_0000,
                                        48'h11_22_33_44_55_66, 1'b0));
      // network with host bits set never matches
      req_backlog.push_back(route_write(4, 32'h0A0A_0A0F, 32'hFFFF_FF00,
                                        48'h77_77_77_77_77_77, 1'b1));
      // non-contiguous mask ranked as a plain number
      req_backlog.push_back(route_write(5, 32'hA0A0_A0A0, 32'hF0F0_F0F0,
                                        48'h55_AA_55_AA_55_AA, 1'b1));
      req_backlog.push_back(route_write(6, 32'hC000_0200, 32'hFFFF_FF00,
                                        48'h66_66_66_66_66_66, 1'b1));
      req_backlog.push_back(route_write(7, 32'h0000_0000, 32'h0000_0000,
                                        48'hDE_AD_BE_EF_00_07, 1'b1));
      req_backlog.push_back(packet_header(1'b0, m0 ^ 48'h1, 32'h4500_0054, 32'h1234_4000,
                                          16'h4011, 32'h0101_0101, 32'h0A00_0005));
      req_backlog.push_back(packet_header(1'b1, m0, 32'h4500_0054, 32'h1234_4000,
                                          16'h4011, 32'h0101_0101, 32'h0A00_0005));
      req_backlog.push_back(packet_header(1'b0, m0, 32'h4500_0054, 32'h1234_4000,
                                          16'h4006, 32'h0101_0101, 32'h0A00_0001));
      req_backlog.push_back(packet_header(1'b1, m1, 32'h4500_0054, 32'h1234_4000,
                                          16'h4006, 32'h0101_0101, 32'h0A00_0001));
      req_backlog.push_back(packet_header(1'b0, m0, 32'h4500_0054, 32'h1234_4000,
                                          16'h0011, 32'h0101_0101, 32'h0A00_0005));
      req_backlog.push_back(packet_header(1'b0, m0, 32'h4500_0054, 32'h1234_4000,
                                          16'h0111, 32'h0101_0101, 32'h0A00_0005));
      req_backlog.push_back(packet_header(1'b1, m1, 32'h4500_0054, 32'h1234_4000,
                                          16'h0201, 32'h0101_0101, 32'h0A01_0203));
      req_backlog.push_back(packet_header(1'b0, m0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          16'hFFFF, 32'hFFFF_FFFF, 32'h0A01_0909));
      req_backlog.push_back(packet_header(1'b0, m0, 32'h4F00_0100, 32'h0000_0000,
                                          16'h3306, 32'h0A00_0002, 32'h0A0A_0A05));
      req_backlog.push_back(packet_header(1'b1, m1, 32'h0000_0000, 32'h0000_0000,
                                          16'h0200, 32'h0000_0000, 32'hA5A5_A5A5));
      req_backlog.push_back(packet_header(1'b1, m1, 32'h4500_05DC, 32'hABCD_0000,
                                          16'h80FF, 32'hC633_6401, 32'hC000_024D));
      req_backlog.push_back(packet_header(1'b0, m0, 32'h4500_0028, 32'h0001_0000,
                                          16'h4001, 32'h0000_0000, 32'hFFFF_FFFF));
      drain_pipeline();
      // empty table search
      write_csr(CSR_ROUTE_COUNT, 48'd0);
      req_backlog.push_back(packet_header(1'b0, m0, 32'h4500_0054, 32'h1234_4000,
                                          16'h4011, 32'h0101_0101, 32'h0A00_0005));
      drain_pipeline();
      // default route left out of the search
      write_csr(CSR_ROUTE_COUNT, 48'd7);
      req_backlog.push_back(packet_header(1'b1, m1, 32'h4500_0054, 32'h1234_4000,
                                          16'h4011, 32'h0101_0101, 32'h7F00_0001));
      drain_pipeline();
      // count above the table size searches the whole table
      write_csr(CSR_ROUTE_COUNT, 48'd15);
      req_backlog.push_back(packet_header(1'b1, m1, 32'h4500_0054, 32'h1234_4000,
                                          16'h4011, 32'h0101_0101, 32'h7F00_0001));
      drain_pipeline();

      // random, sender mostly busy, receiver mostly idle, one long hold-off
      write_csr(CSR_ROUTE_COUNT, 48'd8);
      set_ports(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                $urandom(), $urandom());
      sender_gap_pct <= 11;
      receiver_gap_pct <= 79;
      long_stall_go = 1'b1;
      run_random(RANDOM_ITEMS);

      // random with extreme port settings, sender mostly idle
      write_csr(CSR_ROUTE_COUNT, 48'd15);
      set_ports(48'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      sender_gap_pct <= 79;
      receiver_gap_pct <= 11;
      run_random(RANDOM_ITEMS);

      // random with a partial table, no idling
      write_csr(CSR_ROUTE_COUNT, 48'($urandom_range(7, 1)));
      set_ports(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                $urandom(), $urandom());
      sender_gap_pct <= 0;
      receiver_gap_pct <= 0;
      run_random(RANDOM_ITEMS);

      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("PASS ipv4_forward_header_rewrite");
      end else begin
         $display("FAIL ipv4_forward_header_rewrite");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("FAIL ipv4_forward_header_rewrite");
      $finish;
   end

endmodule

/* ipv4_forward_header_rewrite.f */
sv/ipfwd_pkg.sv
sv/ipfwd_table.sv
sv/ipfwd_pick.sv
sv/ipv4_forward_header_rewrite.sv
tb/tb_ipv4_forward_header_rewrite.sv
